// ===== hdl/icrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval chain reducibility filter package
// Shared constants, controller state type, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package icrf_pkg;

   // Default sizes and the fixed width of the identifier ports.
   localparam int MAX_INTERVALS_DEF = 64;
   localparam int ID_WIDTH_DEF      = 16;
   localparam int IO_W              = 16;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELF_RD,
      ST_SELF_LD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_EMIT
   } state_type;

   // Outcome of comparing the span with one other stored interval.
   typedef enum logic [2:0] {
      CMP_NONE,
      CMP_REDUCE,
      CMP_MOVE_START,
      CMP_MOVE_END
   } cmp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // Store the accepted beat or flag overflow.
      logic read_self;   // Read the interval under test.
      logic take_self;   // Capture it, normalize the span, restart the scan.
      logic read_other;  // Read the interval at the scan index.
      logic compare;     // Apply the comparison outcome to span and index.
      logic k_inc;       // Step the scan index past the interval itself.
      logic set_keep;    // Scan ended with no match.
      logic clr_keep;    // A match made the interval reducible.
      logic next_item;   // Advance to the next interval under test.
      logic finish;      // Clear the set after the final result.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic    k_end;     // Scan index reached the interval count.
      logic    k_self;    // Scan index points at the interval under test.
      logic    last_idx;  // Interval under test is the final stored one.
      cmp_type cmp;       // Outcome of the current comparison.
   } status_type;

endpackage

// ===== hdl/icrf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval chain reducibility filter controller
// Sequences loading, the per-interval table scans, and result emission.
// ----------------------------------------------------------------------------
module icrf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_is_last,
   input  icrf_pkg::status_type   status,
   output icrf_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   icrf_pkg::state_type state_ff;
   icrf_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icrf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         icrf_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (req_is_last) begin
                  state_in = icrf_pkg::ST_SELF_RD;
               end
            end
         end
         icrf_pkg::ST_SELF_RD: begin
            cmd.read_self = 1'b1;
            state_in      = icrf_pkg::ST_SELF_LD;
         end
         icrf_pkg::ST_SELF_LD: begin
            cmd.take_self = 1'b1;
            state_in      = icrf_pkg::ST_SCAN_RD;
         end
         icrf_pkg::ST_SCAN_RD: begin
            // End of a full pass with no match: the interval is kept.
            if (status.k_end) begin
               cmd.set_keep = 1'b1;
               state_in     = icrf_pkg::ST_EMIT;
            end else if (status.k_self) begin
               cmd.k_inc = 1'b1;
            end else begin
               cmd.read_other = 1'b1;
               state_in       = icrf_pkg::ST_SCAN_CMP;
            end
         end
         icrf_pkg::ST_SCAN_CMP: begin
            if (status.cmp == icrf_pkg::CMP_REDUCE) begin
               cmd.clr_keep = 1'b1;
               state_in     = icrf_pkg::ST_EMIT;
            end else begin
               cmd.compare = 1'b1;
               state_in    = icrf_pkg::ST_SCAN_RD;
            end
         end
         icrf_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (status.last_idx) begin
               cmd.finish = 1'b1;
               state_in   = icrf_pkg::ST_IDLE;
            end else begin
               cmd.next_item = 1'b1;
               state_in      = icrf_pkg::ST_SELF_RD;
            end
         end
         default: begin
            state_in = icrf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/icrf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval chain reducibility filter datapath
// Interval memory, set counters, scan index, span registers and comparator.
// ----------------------------------------------------------------------------
module icrf_datapath #(
   parameter int MAX_INTERVALS = icrf_pkg::MAX_INTERVALS_DEF,
   parameter int ID_WIDTH      = icrf_pkg::ID_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  icrf_pkg::cmd_type           cmd,
   input  logic [icrf_pkg::IO_W-1:0]   req_first_id,
   input  logic [icrf_pkg::IO_W-1:0]   req_second_id,
   output icrf_pkg::status_type        status,
   output logic [icrf_pkg::IO_W-1:0]   rsp_out_first_id,
   output logic [icrf_pkg::IO_W-1:0]   rsp_out_second_id,
   output logic                        rsp_keep,
   output logic                        rsp_overflow
);

   localparam int IO_W  = icrf_pkg::IO_W;
   // Stored identifier width: the ports carry 16 bits, masked to ID_WIDTH.
   localparam int SW    = (ID_WIDTH < IO_W) ? ID_WIDTH : IO_W;
   localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

   logic [2*SW-1:0]  mem [MAX_INTERVALS];
   logic [2*SW-1:0]  rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   logic [CNT_W-1:0] count_ff;
   logic             ovf_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] k_ff;
   logic [SW-1:0]    span_s_ff;
   logic [SW-1:0]    span_e_ff;
   logic [SW-1:0]    self_a_ff;
   logic [SW-1:0]    self_b_ff;
   logic             keep_ff;

   logic [SW-1:0]    rd_a;
   logic [SW-1:0]    rd_b;
   logic [SW-1:0]    rd_lo;
   logic [SW-1:0]    rd_hi;
   logic             not_full;
   icrf_pkg::cmp_type cmp;

   assign not_full = (count_ff < CNT_W'(MAX_INTERVALS));
   assign rd_addr  = cmd.read_self ? idx_ff : k_ff[IDX_W-1:0];

   // Interval memory: one write port for loading, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.load && not_full) begin
         mem[count_ff[IDX_W-1:0]] <= {req_second_id[SW-1:0], req_first_id[SW-1:0]};
      end
      if (cmd.read_self || cmd.read_other) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Normalize the entry just read so that its low end comes first.
   assign rd_a  = rd_data_ff[SW-1:0];
   assign rd_b  = rd_data_ff[2*SW-1:SW];
   assign rd_lo = (rd_a > rd_b) ? rd_b : rd_a;
   assign rd_hi = (rd_a > rd_b) ? rd_a : rd_b;

   // Compare the other interval with the current span.
   always_comb begin
      cmp = icrf_pkg::CMP_NONE;
      if (rd_lo != rd_hi) begin
         if (rd_lo == span_s_ff && rd_hi == span_e_ff) begin
            cmp = icrf_pkg::CMP_REDUCE;
         end else if (rd_lo == span_s_ff && rd_hi < span_e_ff) begin
            cmp = icrf_pkg::CMP_MOVE_START;
         end else if (span_s_ff < rd_lo && rd_hi == span_e_ff) begin
            cmp = icrf_pkg::CMP_MOVE_END;
         end
      end
   end

   assign status.cmp      = cmp;
   assign status.k_end    = (k_ff == count_ff);
   assign status.k_self   = (k_ff == CNT_W'(idx_ff));
   assign status.last_idx = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // Set bookkeeping: fill count, overflow flag and interval under test.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else if (cmd.finish) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (cmd.load) begin
            if (not_full) begin
               count_ff <= count_ff + CNT_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.next_item) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   // Scan index, span and the captured interval under test.
   always_ff @(posedge clock) begin
      if (cmd.take_self) begin
         self_a_ff <= rd_a;
         self_b_ff <= rd_b;
         span_s_ff <= rd_lo;
         span_e_ff <= rd_hi;
         k_ff      <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + CNT_W'(1);
      end else if (cmd.compare) begin
         case (cmp)
            icrf_pkg::CMP_MOVE_START: begin
               span_s_ff <= rd_hi;
               k_ff      <= '0;
            end
            icrf_pkg::CMP_MOVE_END: begin
               span_e_ff <= rd_lo;
               k_ff      <= '0;
            end
            default: begin
               k_ff <= k_ff + CNT_W'(1);
            end
         endcase
      end
      if (cmd.set_keep) begin
         keep_ff <= 1'b1;
      end else if (cmd.clr_keep) begin
         keep_ff <= 1'b0;
      end
   end

   // Result fields.
   assign rsp_out_first_id  = IO_W'(self_a_ff);
   assign rsp_out_second_id = IO_W'(self_b_ff);
   assign rsp_keep          = keep_ff;
   assign rsp_overflow      = ovf_ff;

endmodule

// ===== hdl/interval_chain_reducibility_filter.sv =====
`timescale 1ns / 1ps
// A beat that is not last is stored, and busy stays low.
// A last beat starts evaluation; each stored interval is read and captured, then
// scanned: in each pass over the interval memory, every other interval is read and
// compared and the interval itself is skipped; each start or end move restarts the pass.
// One result strobe per interval; a match ends the scan of its interval early.
// Reset is synchronous and clears the set; the receiver cannot stall results.
// ----------------------------------------------------------------------------
// Interval chain reducibility filter
// Loads a set of intervals and flags each one that other intervals can build.
// ----------------------------------------------------------------------------
module interval_chain_reducibility_filter #(
   parameter int MAX_INTERVALS = icrf_pkg::MAX_INTERVALS_DEF,
   parameter int ID_WIDTH      = icrf_pkg::ID_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [icrf_pkg::IO_W-1:0]   req_first_id,
   input  logic [icrf_pkg::IO_W-1:0]   req_second_id,
   input  logic                        req_is_last,
   output logic                        rsp_valid,
   output logic [icrf_pkg::IO_W-1:0]   rsp_out_first_id,
   output logic [icrf_pkg::IO_W-1:0]   rsp_out_second_id,
   output logic                        rsp_keep,
   output logic                        rsp_overflow,
   output logic                        rsp_last_result
);

   icrf_pkg::cmd_type    cmd;
   icrf_pkg::status_type status;

   // Control sequencer.
   icrf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_last (req_is_last),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   // Storage and comparison datapath.
   icrf_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .ID_WIDTH      (ID_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_first_id      (req_first_id),
      .req_second_id     (req_second_id),
      .status            (status),
      .rsp_out_first_id  (rsp_out_first_id),
      .rsp_out_second_id (rsp_out_second_id),
      .rsp_keep          (rsp_keep),
      .rsp_overflow      (rsp_overflow)
   );

   // The final result beat is the one for the last stored interval.
   assign rsp_last_result = status.last_idx;

endmodule

// ===== hdl/icrf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval chain reducibility filter checker
// Port-level properties of the load and evaluation sequencing.
// ----------------------------------------------------------------------------
module icrf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_is_last,
   input logic rsp_valid,
   input logic rsp_last_result
);

   // Results appear only while the block is busy evaluating.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result beat while idle");

   // A beat that is not last is stored without leaving the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_is_last) |=> !busy)
      else $error("busy after a non-last beat");

   // A last beat starts evaluation.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_is_last) |=> busy)
      else $error("evaluation did not start");

   // The final result beat returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |=> !busy)
      else $error("still busy after the final result");

   // Result beats are never adjacent: each needs a fresh table read.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("back-to-back result beats");

endmodule

bind interval_chain_reducibility_filter icrf_checker u_icrf_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_is_last     (req_is_last),
   .rsp_valid       (rsp_valid),
   .rsp_last_result (rsp_last_result)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval chain reducibility filter testbench
// Loads sets of intervals through the command port and checks every result
// beat against a scoreboard that predicts which intervals can be built from
// the others. Directed sets cover duplicates, zero-length intervals, start
// and end moves, and the identifier extremes. Random sets mix full-range
// identifiers, dense identifier pools and built-up chains, and include one
// full set and one overflowing set, under several sender idle patterns.
// ----------------------------------------------------------------------------
module testbench;

   localparam int IDW      = icrf_pkg::IO_W;
   localparam int CAPACITY = icrf_pkg::MAX_INTERVALS_DEF;

   typedef logic [IDW-1:0] id_type;

   // One interval as driven on the request port.
   typedef struct {
      id_type first_id;
      id_type second_id;
   } interval_pair_type;

   // One result beat as expected on the response port.
   typedef struct {
      id_type first_id;
      id_type second_id;
      logic   keep;
      logic   overflow;
      logic   last_result;
   } filter_result_type;

   // Scoreboard: holds the loaded set, predicts the results of each set and
   // checks the response beats in order.
   class interval_scoreboard;
      id_type            held_first[CAPACITY];
      id_type            held_second[CAPACITY];
      int unsigned       held_count;
      bit                dropped_any;
      filter_result_type expected_q[$];
      int unsigned       error_count;
      int unsigned       beats_noted;
      int unsigned       sets_closed;
      int unsigned       results_checked;
      int unsigned       kept_seen;
      int unsigned       overflow_seen;

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Scan the other intervals, shrinking the span on each start or end
      // move, until an exact match is found or a full pass finds nothing.
      function bit span_reducible(int unsigned self, int unsigned n);
         id_type      s, e, os, oe;
         bit          again;
         int unsigned k;
         s = (held_first[self] > held_second[self]) ? held_second[self] : held_first[self];
         e = (held_first[self] > held_second[self]) ? held_first[self] : held_second[self];
         again = 1'b1;
         while (again) begin
            again = 1'b0;
            for (k = 0; k < n; k++) begin
               if (k == self) continue;
               os = (held_first[k] > held_second[k]) ? held_second[k] : held_first[k];
               oe = (held_first[k] > held_second[k]) ? held_first[k] : held_second[k];
               // A zero-length interval never matches.
               if (os == oe) continue;
               if (os == s && oe == e) return 1'b1;
               if (os == s && oe < e) begin
                  s = oe;
                  again = 1'b1;
                  break;
               end
               if (s < os && oe == e) begin
                  e = os;
                  again = 1'b1;
                  break;
               end
            end
         end
         return 1'b0;
      endfunction

      // Record an accepted request beat; a last beat closes the set.
      function void note_beat(id_type first_id, id_type second_id, logic is_last);
         id_type            id_mask;
         filter_result_type r;
         int unsigned       i;
         id_mask = id_type'((64'd1 << icrf_pkg::ID_WIDTH_DEF) - 1);
         beats_noted++;
         if (held_count < CAPACITY) begin
            held_first[held_count]  = first_id & id_mask;
            held_second[held_count] = second_id & id_mask;
            held_count++;
         end else begin
            dropped_any = 1'b1;
         end
         if (is_last !== 1'b1) return;
         for (i = 0; i < held_count; i++) begin
            r.first_id    = held_first[i];
            r.second_id   = held_second[i];
            r.keep        = !span_reducible(i, held_count);
            r.overflow    = dropped_any;
            r.last_result = (i + 1 == held_count);
            expected_q.insert(expected_q.size(), r);
         end
         held_count  = 0;
         dropped_any = 1'b0;
         sets_closed++;
      endfunction

      // Compare one response beat with the oldest expectation.
      function void check_result(id_type first_id, id_type second_id, logic keep,
                                 logic overflow, logic last_result);
         filter_result_type x;
         if (expected_q.size() == 0) begin
            $error("rsp_valid: result with no expectation waiting (ids %h %h)",
                   first_id, second_id);
            error_count++;
            return;
         end
         x = expected_q.pop_front();
         results_checked++;
         if (keep === 1'b1) kept_seen++;
         if (overflow === 1'b1) overflow_seen++;
         if (first_id !== x.first_id) begin
            $error("rsp_out_first_id: expected %h, got %h", x.first_id, first_id);
            error_count++;
         end
         if (second_id !== x.second_id) begin
            $error("rsp_out_second_id: expected %h, got %h", x.second_id, second_id);
            error_count++;
         end
         if (keep !== x.keep) begin
            $error("rsp_keep: expected %b, got %b", x.keep, keep);
            error_count++;
         end
         if (overflow !== x.overflow) begin
            $error("rsp_overflow: expected %b, got %b", x.overflow, overflow);
            error_count++;
         end
         if (last_result !== x.last_result) begin
            $error("rsp_last_result: expected %b, got %b", x.last_result, last_result);
            error_count++;
         end
      endfunction
   endclass

   logic   clock         = 1'b0;
   logic   reset         = 1'b1;
   logic   start         = 1'b0;
   id_type req_first_id  = '0;
   id_type req_second_id = '0;
   logic   req_is_last   = 1'b0;
   logic   busy;
   logic   rsp_valid;
   id_type rsp_out_first_id;
   id_type rsp_out_second_id;
   logic   rsp_keep;
   logic   rsp_overflow;
   logic   rsp_last_result;

   interval_scoreboard sb = new;
   interval_pair_type  set_q[$];
   int unsigned        random_beats;

   interval_chain_reducibility_filter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_id     (req_first_id),
      .req_second_id    (req_second_id),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_out_first_id (rsp_out_first_id),
      .rsp_out_second_id(rsp_out_second_id),
      .rsp_keep         (rsp_keep),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_result  (rsp_last_result)
   );

   always #5 clock = ~clock;

   // Monitor: note accepted request beats, then check response beats.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_beat(req_first_id, req_second_id, req_is_last);
      if (!reset && rsp_valid)
         sb.check_result(rsp_out_first_id, rsp_out_second_id, rsp_keep,
                         rsp_overflow, rsp_last_result);
   end

   function void add_pair(id_type a, id_type b);
      interval_pair_type p;
      p.first_id  = a;
      p.second_id = b;
      set_q.insert(set_q.size(), p);
   endfunction

   // Random intervals whose identifiers come from a pool of the given size
   // at a random base; a pool of 65536 gives full-range identifiers.
   function void add_pool_pairs(int unsigned count, int unsigned pool);
      int unsigned base, i;
      base = $urandom_range(65536 - pool, 0);
      for (i = 0; i < count; i++)
         add_pair(id_type'(base + $urandom_range(pool - 1, 0)),
                  id_type'(base + $urandom_range(pool - 1, 0)));
   endfunction

   // A chain of adjacent segments in random orientation plus covering spans, in
   // random order, so that start and end moves lead to exact matches.
   function void add_chain(int unsigned segments);
      int unsigned       pts[$];
      int unsigned       i, j, a, b;
      interval_pair_type tmp;
      pts.insert(pts.size(), $urandom_range(65535 - 8 * segments, 0));
      for (i = 0; i < segments; i++)
         pts.insert(pts.size(), pts[i] + $urandom_range(8, 1));
      for (i = 0; i < segments; i++)
         if ($urandom_range(1, 0)) add_pair(id_type'(pts[i]), id_type'(pts[i + 1]));
         else add_pair(id_type'(pts[i + 1]), id_type'(pts[i]));
      for (i = 0; i < $urandom_range(2, 1); i++) begin
         a = $urandom_range(segments - 1, 0);
         b = $urandom_range(segments, a + 1);
         add_pair(id_type'(pts[b]), id_type'(pts[a]));
      end
      // Shuffle so the scan meets the pieces in any order.
      for (i = set_q.size() - 1; i > 0; i--) begin
         j        = $urandom_range(i, 0);
         tmp      = set_q[i];
         set_q[i] = set_q[j];
         set_q[j] = tmp;
      end
   endfunction

   // Drive one request beat, with an optional idle gap first, and return at
   // the edge that accepts it.
   task automatic drive_beat(interval_pair_type p, logic last, int unsigned gap_pct);
      int unsigned gap;
      gap = ($urandom_range(99, 0) < gap_pct) ? $urandom_range(4, 1) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_first_id  <= p.first_id;
      req_second_id <= p.second_id;
      req_is_last   <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Send the queued set, marking its final beat as last.
   task automatic drive_set(int unsigned gap_pct);
      int unsigned idx;
      for (idx = 0; idx < set_q.size(); idx++)
         drive_beat(set_q[idx], idx == set_q.size() - 1, gap_pct);
      set_q.delete();
   endtask

   initial begin
      int unsigned set_idx, gap_pct, size, kind;
      random_beats = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed sets.
      add_pair(16'hFFFF, 16'h0000);
      drive_set(0);
      // Identical duplicates in both orientations, and zero-length twins.
      add_pair(16'h0005, 16'h0009);
      add_pair(16'h0009, 16'h0005);
      add_pair(16'h0007, 16'h0007);
      add_pair(16'h0007, 16'h0007);
      drive_set(0);
      // Start move followed by an exact match.
      add_pair(16'h0001, 16'h0003);
      add_pair(16'h0006, 16'h0003);
      add_pair(16'h0001, 16'h0006);
      drive_set(0);
      // End move followed by an exact match.
      add_pair(16'h0014, 16'h000A);
      add_pair(16'h000F, 16'h0014);
      add_pair(16'h000A, 16'h000F);
      drive_set(0);
      // A zero-length interval never matches; nothing here is reducible.
      add_pair(16'h0002, 16'h0002);
      add_pair(16'h0002, 16'h0005);
      add_pair(16'h8000, 16'h7FFF);
      drive_set(0);
      // Start move, end move, then a match.
      add_pair(16'h0009, 16'h0000);
      add_pair(16'h0000, 16'h0003);
      add_pair(16'h0006, 16'h0009);
      add_pair(16'h0003, 16'h0006);
      drive_set(0);

      // Random sets under rotating sender idle patterns.
      set_idx = 0;
      while (random_beats < 180) begin
         case (set_idx % 4)
            1:       gap_pct = 61;
            3:       gap_pct = 9;
            default: gap_pct = 0;
         endcase
         if (set_idx == 5) begin
            // A set that fills the store exactly.
            add_pool_pairs(CAPACITY, 8);
         end else if (set_idx == 10) begin
            // Two beats past capacity; the dropped last beat starts evaluation.
            add_pool_pairs(CAPACITY + 2, 8);
         end else begin
            kind = $urandom_range(9, 0);
            size = $urandom_range(8, 1);
            if (kind < 2) add_pool_pairs(size, 65536);
            else if (kind < 6) add_pool_pairs(size, 6);
            else add_chain($urandom_range(4, 1));
         end
         random_beats += set_q.size();
         // Once, hold the sender off until the previous set has drained.
         if (set_idx == 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         drive_set(gap_pct);
         set_idx++;
      end

      // Drain the remaining results and allow for trailing beats.
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("summary: %0d request beats in %0d sets, %0d result beats checked",
               sb.beats_noted, sb.sets_closed, sb.results_checked);
      $display("summary: %0d intervals kept, %0d removed, %0d flagged with overflow",
               sb.kept_seen, sb.results_checked - sb.kept_seen, sb.overflow_seen);
      if (sb.error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Watchdog.
   initial begin
      #10_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
